// File: rtl/steering_gear_input_port_unit_macros.svh
// assertion macros shared by the checker
`ifndef STEERING_GEAR_INPUT_PORT_UNIT_MACROS_SVH
`define STEERING_GEAR_INPUT_PORT_UNIT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define SGIP_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication on the same edge
`define SGIP_CHECK_NOW(label, ante, cons, msg) \
   `SGIP_CHECK(label, (ante) |-> (cons), msg)

// implication on the following edge
`define SGIP_CHECK_NEXT(label, ante, cons, msg) \
   `SGIP_CHECK(label, (ante) |=> (cons), msg)

`endif

// File: rtl/sgip_pkg.sv
// shared constants and types of the steering and gear input port
package sgip_pkg;

   localparam int BACKLOG_BITS_DEFAULT = 12;
   localparam int CSR_ADDR_BITS        = 4;
   localparam int CSR_DATA_BITS        = 32;

   // port offsets
   localparam logic [1:0] OFS_DIP_A = 2'd0;
   localparam logic [1:0] OFS_DIP_B = 2'd1;
   localparam logic [1:0] OFS_GEAR  = 2'd2;
   localparam logic [1:0] OFS_STEER = 2'd3;

   // register indexes
   localparam logic [1:0] REG_DIP_A = 2'd0;
   localparam logic [1:0] REG_DIP_B = 2'd1;
   localparam logic [1:0] REG_DIP_C = 2'd2;

   // gear numbers and their read codes
   localparam logic [2:0] GEAR_1 = 3'd1;
   localparam logic [2:0] GEAR_2 = 3'd2;
   localparam logic [2:0] GEAR_3 = 3'd3;
   localparam logic [2:0] GEAR_4 = 3'd4;

   localparam logic [7:0] GEAR_1_CODE = 8'he0;
   localparam logic [7:0] GEAR_2_CODE = 8'hd0;
   localparam logic [7:0] GEAR_3_CODE = 8'hb0;
   localparam logic [7:0] GEAR_4_CODE = 8'h70;

   // steering pulse bytes
   localparam logic [7:0] PULSE_RIGHT = 8'hc0;
   localparam logic [7:0] PULSE_LEFT  = 8'h80;
   localparam logic [7:0] PULSE_NONE  = 8'h00;

   // wheel wrap bounds
   localparam logic signed [9:0] WRAP_HIGH = 10'sd128;
   localparam logic signed [9:0] WRAP_SPAN = 10'sd256;

   typedef struct packed {
      logic fire;   // item leaves the input register this cycle
      logic steer;  // item is an offset 3 read
   } step_ctl_type;

endpackage

// File: rtl/sgip_gear.sv
// gear latch with priority switch select and read code
module sgip_gear (
   input  logic                  clock,
   input  logic                  reset,
   input  sgip_pkg::step_ctl_type ctl,
   input  logic [3:0]            gear_switches,
   output logic [7:0]            gear_code
);

   logic [2:0] gear_ff;
   logic [2:0] gear_in;

   always_comb begin
      if (gear_switches[0]) begin
         gear_in = sgip_pkg::GEAR_1;
      end else if (gear_switches[1]) begin
         gear_in = sgip_pkg::GEAR_2;
      end else if (gear_switches[2]) begin
         gear_in = sgip_pkg::GEAR_3;
      end else if (gear_switches[3]) begin
         gear_in = sgip_pkg::GEAR_4;
      end else begin
         gear_in = gear_ff;
      end
   end

   // code reflects the latch as updated by this read
   always_comb begin
      case (gear_in)
         sgip_pkg::GEAR_1: gear_code = sgip_pkg::GEAR_1_CODE;
         sgip_pkg::GEAR_2: gear_code = sgip_pkg::GEAR_2_CODE;
         sgip_pkg::GEAR_3: gear_code = sgip_pkg::GEAR_3_CODE;
         default:          gear_code = sgip_pkg::GEAR_4_CODE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gear_ff <= sgip_pkg::GEAR_1;
      end else if (ctl.fire) begin
         gear_ff <= gear_in;
      end
   end

endmodule

// File: rtl/sgip_steer.sv
// wheel delta, pulse backlog with saturation and pulse select
module sgip_steer #(
   parameter int BACKLOG_BITS = sgip_pkg::BACKLOG_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sgip_pkg::step_ctl_type ctl,
   input  logic [7:0]            wheel_position,
   output logic [7:0]            pulse
);

   localparam logic signed [BACKLOG_BITS:0] LIM =
      (BACKLOG_BITS+1)'((1 << (BACKLOG_BITS - 1)) - 1);
   localparam logic signed [BACKLOG_BITS:0] NLIM = -LIM;

   logic        [7:0]              prev_ff;
   logic signed [BACKLOG_BITS-1:0] backlog_ff;
   logic signed [BACKLOG_BITS-1:0] backlog_in;

   logic signed [9:0]              raw_d;
   logic signed [9:0]              wrap_d;
   logic signed [9:0]              neg_d;
   logic signed [9:0]              quo;
   logic signed [6:0]              quo_n;
   logic signed [BACKLOG_BITS:0]   sum;
   logic signed [BACKLOG_BITS:0]   sat;
   logic signed [BACKLOG_BITS-1:0] sat_n;

   always_comb begin
      raw_d = $signed({2'b00, wheel_position}) - $signed({2'b00, prev_ff});
      if (raw_d > sgip_pkg::WRAP_HIGH) begin
         wrap_d = raw_d - sgip_pkg::WRAP_SPAN;
      end else if (raw_d < -sgip_pkg::WRAP_HIGH) begin
         wrap_d = raw_d + sgip_pkg::WRAP_SPAN;
      end else begin
         wrap_d = raw_d;
      end
      // divide by four, rounding toward zero
      neg_d = -wrap_d;
      quo   = wrap_d[9] ? -(neg_d >>> 2) : (wrap_d >>> 2);
      quo_n = quo[6:0];

      sum = $signed({backlog_ff[BACKLOG_BITS-1], backlog_ff})
          + $signed({{(BACKLOG_BITS-6){quo_n[6]}}, quo_n});
      if (sum > LIM) begin
         sat = LIM;
      end else if (sum < NLIM) begin
         sat = NLIM;
      end else begin
         sat = sum;
      end
      sat_n = sat[BACKLOG_BITS-1:0];

      if (sat_n > 0) begin
         backlog_in = sat_n - $signed({{(BACKLOG_BITS-1){1'b0}}, 1'b1});
         pulse      = sgip_pkg::PULSE_RIGHT;
      end else if (sat_n < 0) begin
         backlog_in = sat_n + $signed({{(BACKLOG_BITS-1){1'b0}}, 1'b1});
         pulse      = sgip_pkg::PULSE_LEFT;
      end else begin
         backlog_in = sat_n;
         pulse      = sgip_pkg::PULSE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         backlog_ff <= '0;
      end else if (ctl.fire && ctl.steer) begin
         prev_ff    <= wheel_position;
         backlog_ff <= backlog_in;
      end
   end

endmodule

// File: rtl/steering_gear_input_port_unit.sv
// top level of the steering and gear input port
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_offset, req_wheel_position, req_gear_switches
//   rsp      out        rsp_valid / rsp_stall  rsp_read_data
//   csr      in         apb write/read         dip banks a, b, c at 0x0, 0x4, 0x8
//
// one beat per cycle unless stalled; a beat passes the input register, then the result register
// the rate is set by the input and result registers, with one pass of logic between
// reset is synchronous: gear 1, wheel and backlog zero, dip banks zero, both stages empty
// a stalled result holds; the input stage stalls only when it is full and the result is held
module steering_gear_input_port_unit #(
   parameter int BACKLOG_BITS = sgip_pkg::BACKLOG_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_offset,
   input  logic [7:0]                         req_wheel_position,
   input  logic [3:0]                         req_gear_switches,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_read_data,

   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sgip_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sgip_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [sgip_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [1:0] in_offset_ff;
   logic [7:0] in_wheel_ff;
   logic [3:0] in_switches_ff;

   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_data_ff;
   logic [7:0] out_data_in;

   logic [7:0] dip_a_ff;
   logic [7:0] dip_b_ff;
   logic [7:0] dip_c_ff;

   logic       out_free;
   logic       accept;
   logic       csr_write;
   logic [1:0] csr_index;
   logic [7:0] gear_code;
   logic [7:0] pulse;

   sgip_pkg::step_ctl_type ctl;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign ctl.fire  = in_valid_ff && out_free;
   assign ctl.steer = (in_offset_ff == sgip_pkg::OFS_STEER);

   assign in_valid_in  = accept || (in_valid_ff && !ctl.fire);
   assign out_valid_in = ctl.fire || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_offset_ff   <= req_offset;
         in_wheel_ff    <= req_wheel_position;
         in_switches_ff <= req_gear_switches;
      end
      if (ctl.fire) begin
         out_data_ff <= out_data_in;
      end
   end

   sgip_gear u_gear (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .gear_switches (in_switches_ff),
      .gear_code     (gear_code)
   );

   sgip_steer #(
      .BACKLOG_BITS (BACKLOG_BITS)
   ) u_steer (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .wheel_position (in_wheel_ff),
      .pulse          (pulse)
   );

   always_comb begin
      case (in_offset_ff)
         sgip_pkg::OFS_DIP_A: out_data_in = dip_a_ff;
         sgip_pkg::OFS_DIP_B: out_data_in = dip_b_ff;
         sgip_pkg::OFS_GEAR:  out_data_in = gear_code;
         default:             out_data_in = dip_c_ff | pulse;
      endcase
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dip_a_ff <= '0;
         dip_b_ff <= '0;
         dip_c_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            sgip_pkg::REG_DIP_A: dip_a_ff <= csr_pwdata[7:0];
            sgip_pkg::REG_DIP_B: dip_b_ff <= csr_pwdata[7:0];
            sgip_pkg::REG_DIP_C: dip_c_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         sgip_pkg::REG_DIP_A: csr_prdata = {24'd0, dip_a_ff};
         sgip_pkg::REG_DIP_B: csr_prdata = {24'd0, dip_b_ff};
         sgip_pkg::REG_DIP_C: csr_prdata = {24'd0, dip_c_ff};
         default:             csr_prdata = '0;
      endcase
   end

endmodule

// File: rtl/sgip_checker.sv
// port-level checks of the steering and gear input port, bound to the top level
`include "steering_gear_input_port_unit_macros.svh"

module sgip_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [7:0]                         rsp_read_data,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic [sgip_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [sgip_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [sgip_pkg::CSR_DATA_BITS-1:0] csr_prdata
);

   // a held result beat keeps its data
   `SGIP_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_data), "rsp beat changed while stalled")

   // input side only backs up when a result is waiting and held
   `SGIP_CHECK_NOW(a_req_stall_cause, req_stall, rsp_valid && rsp_stall, "req stalled without a held result")

   // dip bank a reads back what was written
   `SGIP_CHECK(a_csr_readback, (csr_psel && csr_penable && csr_pwrite && csr_paddr[3:2] == sgip_pkg::REG_DIP_A) ##1 (csr_paddr[3:2] == sgip_pkg::REG_DIP_A) |-> (csr_prdata[7:0] == $past(csr_pwdata[7:0])), "dip bank a readback mismatch")

endmodule

bind steering_gear_input_port_unit sgip_checker u_sgip_checker (.*);
